### hw/rtl/mfre_pkg.sv
// ----------------------------------------------------------------------------
// mfre_pkg
// Shared types and codes for the monochrome framebuffer raster engine.
// ----------------------------------------------------------------------------
package mfre_pkg;

	// Signed coordinate width, wide enough for padding ranges
	localparam int CW = 12;

	typedef logic signed [CW-1:0] coord_t;

	typedef enum logic [3:0] {
		OP_SET     = 4'd0,
		OP_CLR     = 4'd1,
		OP_INV     = 4'd2,
		OP_RDPIX   = 4'd3,
		OP_FILL    = 4'd4,
		OP_BOXCLR  = 4'd5,
		OP_BOXINV  = 4'd6,
		OP_FRAME   = 4'd7,
		OP_HLINE   = 4'd8,
		OP_CLRALL  = 4'd9,
		OP_PADEDGE = 4'd10,
		OP_PADIN   = 4'd11,
		OP_RDBYTE  = 4'd12,
		OP_SHL     = 4'd13,
		OP_SHR     = 4'd14,
		OP_NOP     = 4'd15
	} op_t;

	// What a byte walk does to each byte
	typedef enum logic [2:0] {
		K_BOX,
		K_FRAME,
		K_PAD,
		K_SHL,
		K_SHR
	} kind_t;

	typedef enum logic [1:0] {
		M_SET,
		M_CLR,
		M_INV
	} mode_t;

	// How far a walk goes: one byte, one page, the whole store
	typedef enum logic [1:0] {
		SC_ONE,
		SC_PAGE,
		SC_ALL
	} scope_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK_RD,
		S_WALK_WR,
		S_READ,
		S_RTAKE,
		S_ROW_SETUP,
		S_CNT,
		S_CNT_END,
		S_PAD_EVAL,
		S_ROW_NEXT,
		S_DONE
	} state_t;

	// Geometry handed to the byte calculator. For padding, bx1..bx2 and
	// by1..by2 are the two column ranges and row is the padded row.
	typedef struct packed {
		kind_t  kind;
		mode_t  mode;
		coord_t bx1;
		coord_t bx2;
		coord_t by1;
		coord_t by2;
		coord_t row;
	} calc_ctl_t;

endpackage

### hw/rtl/mfre_ram.sv
// ----------------------------------------------------------------------------
// mfre_ram
// Single-port frame store, one byte per entry, registered read data.
// ----------------------------------------------------------------------------
module mfre_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// read-first port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### hw/rtl/mfre_bytecalc.sv
// ----------------------------------------------------------------------------
// mfre_bytecalc
// Computes the new value of one page byte for box, frame and padding walks.
// ----------------------------------------------------------------------------
module mfre_bytecalc import mfre_pkg::*; #(
	parameter int SCREEN_WIDTH = 128,
	parameter int KW           = 7,
	parameter int PGW          = 4
) (
	input  calc_ctl_t        ctl,
	input  logic [KW-1:0]    k,
	input  logic [PGW-1:0]   pg,
	input  logic [7:0]       old,
	output logic [7:0]       result
);

	coord_t     x;
	coord_t     r;
	logic       in1;
	logic       in2;
	logic [7:0] mask;

	// per-bit hit mask over the eight rows of this byte
	always_comb begin
		x    = coord_t'(SCREEN_WIDTH - 1) - coord_t'(k);
		in1  = (x >= ctl.bx1) && (x <= ctl.bx2);
		in2  = (x >= ctl.by1) && (x <= ctl.by2);
		mask = '0;
		r    = '0;
		for (int b = 0; b < 8; b++) begin
			r = coord_t'({pg, 3'(b)});
			case (ctl.kind)
				K_BOX: begin
					mask[7-b] = in1 && (r >= ctl.by1) && (r <= ctl.by2);
				end
				K_FRAME: begin
					mask[7-b] = (in1 && ((r == ctl.by1) || (r == ctl.by2))) ||
						(((x == ctl.bx1) || (x == ctl.bx2)) &&
						(r > ctl.by1) && (r < ctl.by2));
				end
				K_PAD: begin
					mask[7-b] = (r == ctl.row) && (in1 || in2);
				end
				default: begin
					mask[7-b] = 1'b0;
				end
			endcase
		end
	end

	// apply mask: boxes honor the mode, frame and padding only set
	always_comb begin
		if (ctl.kind == K_BOX) begin
			case (ctl.mode)
				M_SET:   result = old | mask;
				M_CLR:   result = old & ~mask;
				M_INV:   result = old ^ mask;
				default: result = old;
			endcase
		end else begin
			result = old | mask;
		end
	end

endmodule

### hw/rtl/mono_framebuffer_raster_engine.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_raster_engine
// Drawing engine over a 1-bit page framebuffer of SCREEN_WIDTH x SCREEN_HEIGHT
// pixels held in one single-port byte memory (pixel x,y in byte
// BUFSIZE-1-x-(y/8)*SCREEN_WIDTH, bit 7-y%8). Each request carries one command
// and yields one result. The one memory port does a read and a write back per
// byte for every walk. Box, frame, line and both shifts walk the whole store;
// clear all writes every byte; padding counts the lit pixels of each row in
// range and walks that row's page only for rows that need pixels lit.
// Off-screen pixel commands and empty padding ranges finish without touching
// the store. After reset a clearing pass over the whole store runs before the
// first request is taken. A new request is taken while the previous result
// still waits in the output register.
// ----------------------------------------------------------------------------
module mono_framebuffer_raster_engine import mfre_pkg::*; #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [3:0]        opcode,
	input  logic signed [9:0] x_first,
	input  logic signed [9:0] y_first,
	input  logic signed [9:0] x_last,
	input  logic signed [9:0] y_last,
	input  logic [8:0]        min_lit,
	input  logic signed [9:0] inner_left,
	input  logic signed [9:0] inner_right,
	input  logic [9:0]        byte_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              pixel_lit,
	output logic [7:0]        byte_data
);

	localparam int PAGES    = SCREEN_HEIGHT / 8;
	localparam int BUFSIZE  = SCREEN_WIDTH * PAGES;
	localparam int VIS_ROWS = PAGES * 8;
	localparam int AW       = $clog2(BUFSIZE);
	localparam int AW1      = AW + 1;
	localparam int KW       = $clog2(SCREEN_WIDTH);
	localparam int PGW      = $clog2(PAGES + 1);
	localparam int CNTW     = $clog2(SCREEN_WIDTH + 1);
	localparam int SHR_N    = 4 * (SCREEN_WIDTH / 4 - 1);

	state_t          state_q, state_d;
	calc_ctl_t       ctl_q;
	scope_t          scope_q;
	logic [AW1-1:0]  base_q;
	logic [PGW-1:0]  pg_q;
	logic [KW-1:0]   k_q;
	logic [AW-1:0]   cl_q;
	logic            clr_cmd_q;
	coord_t          rlast_q;
	logic [8:0]      need_q;
	logic            inside_q;
	coord_t          ia_q;
	coord_t          ib_q;
	logic [CNTW-1:0] cnt_q;
	logic            rv_s1;
	logic [AW-1:0]   rd_addr_q;
	logic            rd_pix_q;
	logic [2:0]      bitsel_q;
	logic            res_lit_q;
	logic [7:0]      res_byte_q;
	logic            out_valid_q;
	logic            pixel_lit_q;
	logic [7:0]      byte_data_q;

	logic            mem_we;
	logic [AW-1:0]   mem_addr;
	logic [7:0]      mem_wdata;
	logic [7:0]      mem_rdata;
	logic [7:0]      calc_byte;
	logic [7:0]      walk_byte;

	coord_t          x1e, y1e, x2e, y2e;
	logic            onscr;
	logic            hline_ok;
	coord_t          pad_lo, pad_hi;
	logic            pad_ok;
	logic [PGW-1:0]  acc_pg;
	logic [AW1-1:0]  acc_base;
	logic [AW1-1:0]  pix_addr;
	logic [PGW-1:0]  row_pg;
	logic [AW1-1:0]  row_base;
	logic            idx_ok;
	logic            k_end;
	logic            last_page;
	logic [AW1-1:0]  walk_wa;
	logic [AW1-1:0]  walk_ra;
	logic [9:0]      pad_d;
	logic            pad_needed;
	coord_t          d_lo, d_hi;
	logic            out_free;
	logic            in_take;

	mfre_ram #(
		.DEPTH (BUFSIZE),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	mfre_bytecalc #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.KW           (KW),
		.PGW          (PGW)
	) u_calc (
		.ctl    (ctl_q),
		.k      (k_q),
		.pg     (pg_q),
		.old    (mem_rdata),
		.result (calc_byte)
	);

	// request decode helpers
	assign x1e      = coord_t'(x_first);
	assign y1e      = coord_t'(y_first);
	assign x2e      = coord_t'(x_last);
	assign y2e      = coord_t'(y_last);
	assign onscr    = (x1e >= 0) && (x1e < SCREEN_WIDTH) && (y1e >= 0) && (y1e < VIS_ROWS);
	assign hline_ok = (y1e >= 0) && (y1e < SCREEN_HEIGHT);
	assign pad_lo   = (y1e < 0) ? coord_t'(0) : y1e;
	assign pad_hi   = (y2e > VIS_ROWS - 1) ? coord_t'(VIS_ROWS - 1) : y2e;
	assign pad_ok   = pad_lo <= pad_hi;
	assign acc_pg   = PGW'(y1e >>> 3);
	assign acc_base = AW1'((PAGES - 1 - int'(acc_pg)) * SCREEN_WIDTH);
	assign pix_addr = acc_base + AW1'(SCREEN_WIDTH - 1) - AW1'(x1e);
	assign row_pg   = PGW'(ctl_q.row >>> 3);
	assign row_base = AW1'((PAGES - 1 - int'(row_pg)) * SCREEN_WIDTH);
	assign idx_ok   = int'(byte_index) < BUFSIZE;
	assign in_take  = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// walk addressing
	assign k_end     = (ctl_q.kind == K_SHL) ? (k_q == '0) : (k_q == KW'(SCREEN_WIDTH - 1));
	assign last_page = base_q == AW1'(BUFSIZE - SCREEN_WIDTH);
	assign walk_wa   = base_q + AW1'(k_q);

	always_comb begin
		if (ctl_q.kind == K_SHL && k_q != '0) begin
			walk_ra = walk_wa - AW1'(1);
		end else if (ctl_q.kind == K_SHR && int'(k_q) < SHR_N) begin
			walk_ra = walk_wa + AW1'(4);
		end else begin
			walk_ra = walk_wa;
		end
	end

	// byte written back by a walk
	always_comb begin
		case (ctl_q.kind)
			K_SHL: walk_byte = (k_q == '0) ? 8'h00 : mem_rdata;
			K_SHR: begin
				if (int'(k_q) < SHR_N) begin
					walk_byte = mem_rdata;
				end else if (int'(k_q) >= SCREEN_WIDTH - 4) begin
					walk_byte = 8'h00;
				end else begin
					walk_byte = mem_rdata;
				end
			end
			default: walk_byte = calc_byte;
		endcase
	end

	// padding deficit and half widths
	assign pad_needed = 10'(need_q) > 10'(cnt_q);
	assign pad_d      = 10'(need_q) - 10'(cnt_q);
	assign d_lo       = coord_t'(pad_d >> 1);
	assign d_hi       = coord_t'((pad_d + 10'd1) >> 1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (cl_q == AW'(BUFSIZE - 1)) begin
					state_d = clr_cmd_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					case (op_t'(opcode))
						OP_SET, OP_CLR, OP_INV: state_d = onscr ? S_WALK_RD : S_DONE;
						OP_RDPIX:   state_d = onscr ? S_READ : S_DONE;
						OP_FILL, OP_BOXCLR, OP_BOXINV, OP_FRAME,
						OP_SHL, OP_SHR: state_d = S_WALK_RD;
						OP_HLINE:   state_d = hline_ok ? S_WALK_RD : S_DONE;
						OP_CLRALL:  state_d = S_CLEAR;
						OP_PADEDGE, OP_PADIN: state_d = pad_ok ? S_ROW_SETUP : S_DONE;
						OP_RDBYTE:  state_d = idx_ok ? S_READ : S_DONE;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_WALK_RD: state_d = S_WALK_WR;
			S_WALK_WR: begin
				priority if (scope_q == SC_ONE) begin
					state_d = S_DONE;
				end else if (!k_end) begin
					state_d = S_WALK_RD;
				end else if (scope_q == SC_PAGE) begin
					state_d = S_ROW_NEXT;
				end else if (last_page) begin
					state_d = S_DONE;
				end else begin
					state_d = S_WALK_RD;
				end
			end
			S_READ:      state_d = S_RTAKE;
			S_RTAKE:     state_d = S_DONE;
			S_ROW_SETUP: state_d = S_CNT;
			S_CNT: begin
				if (k_q == KW'(SCREEN_WIDTH - 1)) begin
					state_d = S_CNT_END;
				end
			end
			S_CNT_END:   state_d = S_PAD_EVAL;
			S_PAD_EVAL:  state_d = pad_needed ? S_WALK_RD : S_ROW_NEXT;
			S_ROW_NEXT:  state_d = (ctl_q.row == rlast_q) ? S_DONE : S_ROW_SETUP;
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory port and handshake outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = 8'h00;
		mem_addr  = walk_wa[AW-1:0];
		in_stall  = state_q != S_IDLE;
		unique case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = cl_q;
			end
			S_WALK_RD: mem_addr = walk_ra[AW-1:0];
			S_WALK_WR: begin
				mem_we    = 1'b1;
				mem_wdata = walk_byte;
			end
			S_READ:  mem_addr = rd_addr_q;
			default: mem_addr = walk_wa[AW-1:0];
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cl_q        <= '0;
			clr_cmd_q   <= 1'b0;
			rv_s1       <= 1'b0;
			k_q         <= '0;
			base_q      <= '0;
			pg_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= state_q == S_CNT;

			// lit pixel count of the padded row
			if (rv_s1 && mem_rdata[3'd7 - ctl_q.row[2:0]]) begin
				cnt_q <= cnt_q + CNTW'(1);
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLEAR: begin
					cl_q <= (cl_q == AW'(BUFSIZE - 1)) ? '0 : cl_q + AW'(1);
				end
				S_IDLE: begin
					if (in_take) begin
						clr_cmd_q <= op_t'(opcode) == OP_CLRALL;
						cl_q      <= '0;
						base_q    <= '0;
						pg_q      <= PGW'(PAGES - 1);
						k_q       <= (op_t'(opcode) == OP_SHL) ? KW'(SCREEN_WIDTH - 1) : '0;
						if (op_t'(opcode) == OP_SET || op_t'(opcode) == OP_CLR ||
							op_t'(opcode) == OP_INV) begin
							base_q <= acc_base;
							pg_q   <= acc_pg;
							k_q    <= KW'(coord_t'(SCREEN_WIDTH - 1) - x1e);
						end
					end
				end
				S_WALK_WR: begin
					if (!k_end) begin
						k_q <= (ctl_q.kind == K_SHL) ? k_q - KW'(1) : k_q + KW'(1);
					end else if (scope_q == SC_ALL && !last_page) begin
						base_q <= base_q + AW1'(SCREEN_WIDTH);
						pg_q   <= pg_q - PGW'(1);
						k_q    <= (ctl_q.kind == K_SHL) ? KW'(SCREEN_WIDTH - 1) : '0;
					end
				end
				S_ROW_SETUP: begin
					base_q <= row_base;
					pg_q   <= row_pg;
					k_q    <= '0;
					cnt_q  <= '0;
				end
				S_CNT: begin
					if (k_q != KW'(SCREEN_WIDTH - 1)) begin
						k_q <= k_q + KW'(1);
					end
				end
				S_PAD_EVAL: k_q <= '0;
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_take) begin
					res_lit_q     <= 1'b0;
					res_byte_q    <= 8'h00;
					ctl_q.kind    <= K_BOX;
					ctl_q.mode    <= M_SET;
					ctl_q.bx1     <= x1e;
					ctl_q.bx2     <= x2e;
					ctl_q.by1     <= y1e;
					ctl_q.by2     <= y2e;
					ctl_q.row     <= pad_lo;
					scope_q       <= SC_ALL;
					rlast_q       <= pad_hi;
					need_q        <= min_lit;
					inside_q      <= op_t'(opcode) == OP_PADIN;
					ia_q          <= coord_t'(inner_left);
					ib_q          <= coord_t'(inner_right);
					rd_pix_q      <= op_t'(opcode) == OP_RDPIX;
					bitsel_q      <= 3'd7 - y1e[2:0];
					rd_addr_q     <= (op_t'(opcode) == OP_RDPIX) ?
						pix_addr[AW-1:0] : AW'(byte_index);
					case (op_t'(opcode))
						OP_SET, OP_CLR, OP_INV: begin
							scope_q   <= SC_ONE;
							ctl_q.bx2 <= x1e;
							ctl_q.by2 <= y1e;
							ctl_q.mode <= (op_t'(opcode) == OP_SET) ? M_SET :
								(op_t'(opcode) == OP_CLR) ? M_CLR : M_INV;
						end
						OP_BOXCLR: ctl_q.mode  <= M_CLR;
						OP_BOXINV: ctl_q.mode  <= M_INV;
						OP_FRAME:  ctl_q.kind  <= K_FRAME;
						OP_HLINE: begin
							ctl_q.bx1 <= coord_t'(0);
							ctl_q.bx2 <= coord_t'(SCREEN_WIDTH - 1);
							ctl_q.by2 <= y1e;
						end
						OP_PADEDGE, OP_PADIN: begin
							ctl_q.kind <= K_PAD;
							scope_q    <= SC_PAGE;
						end
						OP_SHL: ctl_q.kind <= K_SHL;
						OP_SHR: ctl_q.kind <= K_SHR;
						default: begin
						end
					endcase
				end
			end
			S_RTAKE: begin
				if (rd_pix_q) begin
					res_lit_q <= mem_rdata[bitsel_q];
				end else begin
					res_byte_q <= mem_rdata;
				end
			end
			S_PAD_EVAL: begin
				// column ranges to light, inclusive bounds
				if (inside_q) begin
					ctl_q.bx1 <= ia_q - d_lo;
					ctl_q.bx2 <= ia_q - coord_t'(1);
					ctl_q.by1 <= ib_q;
					ctl_q.by2 <= ib_q + d_hi - coord_t'(1);
				end else begin
					ctl_q.bx1 <= coord_t'(0);
					ctl_q.bx2 <= d_lo - coord_t'(1);
					ctl_q.by1 <= coord_t'(SCREEN_WIDTH) - d_hi;
					ctl_q.by2 <= coord_t'(SCREEN_WIDTH - 1);
				end
			end
			S_ROW_NEXT: begin
				if (ctl_q.row != rlast_q) begin
					ctl_q.row <= ctl_q.row + coord_t'(1);
				end
			end
			S_DONE: begin
				if (out_free) begin
					pixel_lit_q <= res_lit_q;
					byte_data_q <= res_byte_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign pixel_lit = pixel_lit_q;
	assign byte_data = byte_data_q;

	// write-back always follows its own read
	a_walk_pair: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK_WR |-> $past(state_q) == S_WALK_RD)
		else $error("walk write without preceding read");

	// no store writes while waiting for a request or holding a result
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
		else $error("store written outside a command");

	// a result appears only from the completion state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside completion");

	// column counter stays inside a page
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= KW'(SCREEN_WIDTH - 1))
		else $error("column counter out of range");

endmodule

### bench/mfre_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfre_checker
// Watches both channels of the raster engine, keeps its own copy of the page
// framebuffer, predicts every result and compares it with what comes out.
// ----------------------------------------------------------------------------
module mfre_checker import mfre_pkg::*; #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [3:0]        opcode,
	input  logic signed [9:0] x_first,
	input  logic signed [9:0] y_first,
	input  logic signed [9:0] x_last,
	input  logic signed [9:0] y_last,
	input  logic [8:0]        min_lit,
	input  logic signed [9:0] inner_left,
	input  logic signed [9:0] inner_right,
	input  logic [9:0]        byte_index,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              pixel_lit,
	input  logic [7:0]        byte_data,
	output int                fail_count,
	output int                pending
);

	localparam int PAGES   = SCREEN_HEIGHT / 8;
	localparam int BUFSIZE = SCREEN_WIDTH * PAGES;
	localparam int ROWS    = PAGES * 8;

	typedef struct packed {
		logic       lit;
		logic [7:0] data;
	} answer_t;

	logic [7:0] shadow_fb [BUFSIZE];
	answer_t    answer_q [$];

	function automatic bit visible(int x, int y);
		return x >= 0 && y >= 0 && x < SCREEN_WIDTH && y < ROWS;
	endfunction

	function automatic int byte_addr(int x, int y);
		return BUFSIZE - 1 - x - (y / 8) * SCREEN_WIDTH;
	endfunction

	function automatic logic [7:0] bit_mask(int y);
		return 8'h1 << (7 - (y % 8));
	endfunction

	// mode: set, clear or invert one pixel; off-screen is ignored
	function automatic void plot(int x, int y, mode_t m);
		int a;
		if (!visible(x, y))
			return;
		a = byte_addr(x, y);
		case (m)
			M_SET: shadow_fb[a] |= bit_mask(y);
			M_CLR: shadow_fb[a] &= ~bit_mask(y);
			default: shadow_fb[a] ^= bit_mask(y);
		endcase
	endfunction

	function automatic bit peek(int x, int y);
		if (!visible(x, y))
			return 0;
		return (shadow_fb[byte_addr(x, y)] & bit_mask(y)) != 0;
	endfunction

	function automatic void draw_box(int x1, int y1, int x2, int y2, mode_t m);
		if (x1 < 0) x1 = 0;
		if (y1 < 0) y1 = 0;
		if (x2 > SCREEN_WIDTH - 1) x2 = SCREEN_WIDTH - 1;
		if (y2 > SCREEN_HEIGHT - 1) y2 = SCREEN_HEIGHT - 1;
		for (int x = x1; x <= x2; x++)
			for (int y = y1; y <= y2; y++)
				plot(x, y, m);
	endfunction

	function automatic void pad_rows(int y1, int y2, int need, bit inner, int a, int b);
		int cnt;
		int d;
		if (y1 < 0) y1 = 0;
		if (y2 > SCREEN_HEIGHT - 1) y2 = SCREEN_HEIGHT - 1;
		for (int y = y1; y <= y2; y++) begin
			cnt = 0;
			for (int x = 0; x < SCREEN_WIDTH; x++)
				cnt += peek(x, y);
			if (need <= cnt)
				continue;
			d = need - cnt;
			if (inner) begin
				for (int x = a - d / 2; x < a; x++) plot(x, y, M_SET);
				for (int x = b; x < b + (d + 1) / 2; x++) plot(x, y, M_SET);
			end else begin
				for (int x = 0; x < d / 2; x++) plot(x, y, M_SET);
				for (int x = SCREEN_WIDTH - (d + 1) / 2; x < SCREEN_WIDTH; x++)
					plot(x, y, M_SET);
			end
		end
	endfunction

	// Apply one command to the shadow buffer and return its answer
	function automatic answer_t apply_command(logic [3:0] op, int x1, int y1,
			int x2, int y2, int need, int a, int b, int idx);
		answer_t r;
		int base;
		r = '0;
		case (op)
			OP_SET:   plot(x1, y1, M_SET);
			OP_CLR:   plot(x1, y1, M_CLR);
			OP_INV:   plot(x1, y1, M_INV);
			OP_RDPIX: r.lit = peek(x1, y1);
			OP_FILL:   draw_box(x1, y1, x2, y2, M_SET);
			OP_BOXCLR: draw_box(x1, y1, x2, y2, M_CLR);
			OP_BOXINV: draw_box(x1, y1, x2, y2, M_INV);
			OP_FRAME: begin
				for (int x = x1; x <= x2; x++) begin
					plot(x, y1, M_SET);
					plot(x, y2, M_SET);
				end
				for (int y = y1 + 1; y < y2; y++) begin
					plot(x1, y, M_SET);
					plot(x2, y, M_SET);
				end
			end
			OP_HLINE:
				if (y1 >= 0 && y1 < SCREEN_HEIGHT)
					draw_box(0, y1, SCREEN_WIDTH - 1, y1, M_SET);
			OP_CLRALL: foreach (shadow_fb[i]) shadow_fb[i] = '0;
			OP_PADEDGE: pad_rows(y1, y2, need, 0, 0, 0);
			OP_PADIN:   pad_rows(y1, y2, need, 1, a, b);
			OP_RDBYTE:
				if (idx < BUFSIZE)
					r.data = shadow_fb[idx];
			OP_SHL:
				for (int j = 0; j < PAGES; j++) begin
					base = j * SCREEN_WIDTH;
					for (int k = SCREEN_WIDTH - 1; k > 0; k--)
						shadow_fb[base + k] = shadow_fb[base + k - 1];
					shadow_fb[base] = '0;
				end
			OP_SHR:
				for (int j = 0; j < PAGES; j++) begin
					base = j * SCREEN_WIDTH;
					for (int i = 0; i < 4 * (SCREEN_WIDTH / 4 - 1); i++)
						shadow_fb[base + i] = shadow_fb[base + i + 4];
					for (int i = 1; i <= 4; i++)
						shadow_fb[base + SCREEN_WIDTH - i] = '0;
				end
			default: ;
		endcase
		return r;
	endfunction

	assign pending = answer_q.size();

	// Predict on each accepted request, compare on each accepted result
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			foreach (shadow_fb[i]) shadow_fb[i] = '0;
			answer_q.delete();
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				answer_q.push_back(apply_command(opcode, x_first, y_first, x_last,
					y_last, min_lit, inner_left, inner_right, byte_index));
			if (out_valid && !out_stall) begin
				if (answer_q.size() == 0) begin
					if (fail_count < 10)
						$display("mismatch: result with nothing expected lit=%0d data=%02h",
							pixel_lit, byte_data);
					fail_count <= fail_count + 1;
				end else begin
					want = answer_q.pop_front();
					if (want.lit !== pixel_lit || want.data !== byte_data) begin
						if (fail_count < 10)
							$display("mismatch: lit exp %0d got %0d, data exp %02h got %02h",
								want.lit, pixel_lit, want.data, byte_data);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### bench/mono_framebuffer_raster_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_raster_engine_tb
// Drives directed and random drawing commands into the raster engine with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module mono_framebuffer_raster_engine_tb;
	import mfre_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [3:0]        opcode;
	logic signed [9:0] x_first;
	logic signed [9:0] y_first;
	logic signed [9:0] x_last;
	logic signed [9:0] y_last;
	logic [8:0]        min_lit;
	logic signed [9:0] inner_left;
	logic signed [9:0] inner_right;
	logic [9:0]        byte_index;
	logic              out_valid;
	logic              out_stall;
	logic              pixel_lit;
	logic [7:0]        byte_data;
	int                fail_count;
	int                pending;
	bit                long_hold;
	bit                sending_done;

	mono_framebuffer_raster_engine dut (.*);

	mfre_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Send one request and hold it until taken
	task automatic send_cmd(logic [3:0] op, int x1, int y1, int x2, int y2,
			int need, int a, int b, int idx);
		opcode      <= op;
		x_first     <= 10'(x1);
		y_first     <= 10'(y1);
		x_last      <= 10'(x2);
		y_last      <= 10'(y2);
		min_lit     <= 9'(need);
		inner_left  <= 10'(a);
		inner_right <= 10'(b);
		byte_index  <= 10'(idx);
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Mostly on-screen coordinates, sometimes anywhere in the field
	function automatic int coord(int hi);
		if ($urandom_range(0, 7) == 0)
			return $signed(10'($urandom));
		return $urandom_range(0, hi + 4) - 2;
	endfunction

	task automatic random_cmd();
		logic [3:0] op;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)      op = 4'($urandom_range(OP_SET, OP_RDPIX));
		else if (pick < 40) op = OP_RDBYTE;
		else if (pick < 43) op = OP_NOP;
		else if (pick < 46) op = OP_CLRALL;
		else                op = 4'($urandom_range(0, 14));
		send_cmd(op, coord(128), coord(64), coord(128), coord(64),
			$urandom_range(0, 3) == 0 ? $urandom_range(0, 511) : $urandom_range(0, 140),
			coord(128), coord(128), $urandom_range(0, 1023));
	endtask

	// Receiver: random stalls, with one long hold-off on request
	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				long_hold = 0;
			end
			n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
			out_stall <= (n != 0);
			repeat (n) @(posedge clk);
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	initial begin
		#600_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		in_valid <= 1'b0;
		opcode <= '0; x_first <= '0; y_first <= '0; x_last <= '0; y_last <= '0;
		min_lit <= '0; inner_left <= '0; inner_right <= '0; byte_index <= '0;
		long_hold = 0;
		sending_done = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every operation, field extremes, off-screen and reversed
		send_cmd(OP_RDBYTE, 0, 0, 0, 0, 0, 0, 0, 1023);
		send_cmd(OP_SET, 0, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_SET, 127, 63, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_SET, -512, 511, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_RDPIX, 127, 63, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_RDPIX, 128, 64, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_RDBYTE, 0, 0, 0, 0, 0, 0, 0, 1023 - 127 - 7 * 128);
		send_cmd(OP_INV, 0, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_CLR, 127, 63, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_FILL, -512, -512, 511, 511, 0, 0, 0, 0);
		send_cmd(OP_BOXINV, 10, 5, 40, 30, 0, 0, 0, 0);
		send_cmd(OP_BOXCLR, 50, 20, 20, 40, 0, 0, 0, 0);
		send_cmd(OP_RDBYTE, 0, 0, 0, 0, 0, 0, 0, 900);
		send_cmd(OP_CLRALL, 0, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_FRAME, -3, 2, 130, 70, 0, 0, 0, 0);
		send_cmd(OP_HLINE, 0, 63, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_HLINE, 0, -1, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_PADEDGE, 0, -512, 0, 511, 511, 0, 0, 0);
		send_cmd(OP_CLRALL, 0, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_PADIN, 0, 3, 0, 9, 40, 5, 120, 0);
		send_cmd(OP_PADIN, 0, 10, 0, 2, 40, -512, 511, 0);
		send_cmd(OP_SHL, 0, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_SHR, 0, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(OP_RDBYTE, 0, 0, 0, 0, 0, 0, 0, 5);
		send_cmd(OP_NOP, 0, 0, 0, 0, 0, 0, 0, 0);

		// Random, with one long receiver hold-off and one drain pause
		for (int i = 0; i < 555; i++) begin
			if (i == 150)
				long_hold = 1;
			if (i == 300) begin
				in_valid <= 1'b0;
				while (pending != 0) @(posedge clk);
			end
			if ($urandom_range(0, 3) != 0)
				idle_gap($urandom_range(0, 18));
			random_cmd();
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
